// ===== rtl/snms_pkg.sv =====
// Shared types and constants for the sorted-box non-maximum suppression block.
`timescale 1ns / 1ps

package snms_pkg;

  localparam int COORD_W   = 16;  // signed Q12.4 edge
  localparam int EXTENT_W  = 16;  // unsigned Q12.4 width / height
  localparam int EDGE_W    = 18;  // edge plus extent
  localparam int AREA_W    = 32;
  localparam int LEN_W     = 16;  // overlap length never exceeds an extent
  localparam int UNION_W   = 33;
  localparam int THR_W     = 16;
  localparam int PROD_W    = THR_W + UNION_W;
  localparam int NUM_W     = 16;
  localparam int TOTAL_W   = 9;
  localparam int PIPE_LEN  = 5;   // compare pipeline stages after the issue

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;
  localparam logic [NUM_W-1:0] NUM_MAX   = '1;

  // One box handed from the front end to the compare engine.
  typedef struct packed {
    logic                      frame_start;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [EDGE_W-1:0]  right;
    logic signed [EDGE_W-1:0]  bottom;
    logic [AREA_W-1:0]         area;
    logic [NUM_W-1:0]          number;
  } item_t;

  // One entry of the kept-box store.
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [EDGE_W-1:0]  right;
    logic signed [EDGE_W-1:0]  bottom;
    logic [AREA_W-1:0]         area;
  } kept_t;

endpackage

// ===== rtl/snms_if.sv =====
// Valid/ready channel interfaces for boxes, results and threshold writes.
`timescale 1ns / 1ps

interface snms_in_if;
  import snms_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       frame_start;
  logic signed [COORD_W-1:0]  box_left;
  logic signed [COORD_W-1:0]  box_top;
  logic [EXTENT_W-1:0]        box_width;
  logic [EXTENT_W-1:0]        box_height;

  modport source (output valid, frame_start, box_left, box_top, box_width, box_height,
                  input ready);
  modport sink (input valid, frame_start, box_left, box_top, box_width, box_height,
                output ready);
endinterface

interface snms_out_if;
  import snms_pkg::*;
  logic               valid;
  logic               ready;
  logic               keep;
  logic [NUM_W-1:0]   box_number;
  logic [TOTAL_W-1:0] kept_total;
  logic               store_full;

  modport source (output valid, keep, box_number, kept_total, store_full, input ready);
  modport sink (input valid, keep, box_number, kept_total, store_full, output ready);
endinterface

interface snms_cfg_if;
  import snms_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/snms_front.sv =====
// Front end: takes boxes, derives far edges and area, numbers boxes per frame.
`timescale 1ns / 1ps

module snms_front (
  input  logic            clk,
  input  logic            rst_n,
  snms_in_if.sink         in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output snms_pkg::item_t push_data
);
  import snms_pkg::*;

  logic [NUM_W-1:0] cnt_r;
  logic [NUM_W-1:0] cnt_nxt;
  logic [NUM_W-1:0] number;
  logic             xfer;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign xfer        = in_ch.valid && push_ready;

  // A frame start restarts numbering with this box.
  assign number  = in_ch.frame_start ? '0 : cnt_r;
  assign cnt_nxt = (number == NUM_MAX) ? number : number + NUM_W'(1);

  always_comb begin
    push_data.frame_start = in_ch.frame_start;
    push_data.left        = in_ch.box_left;
    push_data.top         = in_ch.box_top;
    push_data.right       = {{(EDGE_W-COORD_W){in_ch.box_left[COORD_W-1]}}, in_ch.box_left}
                            + $signed({{(EDGE_W-EXTENT_W){1'b0}}, in_ch.box_width});
    push_data.bottom      = {{(EDGE_W-COORD_W){in_ch.box_top[COORD_W-1]}}, in_ch.box_top}
                            + $signed({{(EDGE_W-EXTENT_W){1'b0}}, in_ch.box_height});
    push_data.area        = AREA_W'(in_ch.box_width) * AREA_W'(in_ch.box_height);
    push_data.number      = number;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (xfer) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/snms_queue.sv =====
// Two-entry queue between the front end and the compare engine.
`timescale 1ns / 1ps

module snms_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  snms_pkg::item_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output snms_pkg::item_t pop_data
);
  import snms_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  item_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill_r != FILL_W'(DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/snms_back.sv =====
// Compare engine: scans the kept store, decides keep/suppress, appends kept boxes.
`timescale 1ns / 1ps

module snms_back #(
  parameter int KEEP_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [snms_pkg::THR_W-1:0] threshold,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  snms_pkg::item_t            pop_data,
  snms_out_if.source                 out_ch
);
  import snms_pkg::*;

  localparam int IDX_W = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
  localparam int CNT_W = $clog2(KEEP_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_inc;
  logic [CNT_W-1:0]    j_r;
  logic [PIPE_LEN-1:0] pv_r;
  logic                supp_r;
  item_t               cur_r;
  kept_t               mem [KEEP_DEPTH];
  kept_t               rd_r;
  kept_t               wr_entry;

  logic                     issue;
  logic                     scan_done;
  logic                     out_free;
  logic                     room;
  logic                     keep;
  logic                     store;
  logic                     finish;

  // compare pipeline
  logic signed [EDGE_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [EDGE_W-1:0] k_left, k_top, c_left, c_top;
  logic [LEN_W-1:0]         iw, ih;
  logic [LEN_W-1:0]         iw2_r, ih2_r;
  logic [AREA_W-1:0]        karea2_r, karea3_r;
  logic [AREA_W-1:0]        inter3_r, inter4_r, inter5_r;
  logic [UNION_W-1:0]       uni4_r;
  logic [PROD_W-1:0]        prod5_r;
  logic                     nz5_r;
  logic                     over;

  logic                     out_valid_r;
  logic                     keep_r;
  logic [NUM_W-1:0]         number_r;
  logic [TOTAL_W-1:0]       total_r;
  logic                     full_r;

  assign pop_ready = state_r == ST_IDLE;
  assign issue     = (state_r == ST_SCAN) && (j_r < count_r);
  assign scan_done = (state_r == ST_SCAN) && (j_r == count_r) && (pv_r == '0);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign room      = count_r < CNT_W'(KEEP_DEPTH);
  assign keep      = !supp_r;
  assign store     = keep && room;
  assign finish    = (state_r == ST_DONE) && out_free;
  assign count_inc = count_r + CNT_W'(1);

  assign wr_entry.left   = cur_r.left;
  assign wr_entry.top    = cur_r.top;
  assign wr_entry.right  = cur_r.right;
  assign wr_entry.bottom = cur_r.bottom;
  assign wr_entry.area   = cur_r.area;

  // Kept store: undefined until written, only entries below the count are used.
  always_ff @(posedge clk) begin
    if (finish && store) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    rd_r <= mem[j_r[IDX_W-1:0]];
  end

  // Overlap lengths; a positive overlap never exceeds either extent.
  always_comb begin
    k_left = {{(EDGE_W-COORD_W){rd_r.left[COORD_W-1]}}, rd_r.left};
    k_top  = {{(EDGE_W-COORD_W){rd_r.top[COORD_W-1]}}, rd_r.top};
    c_left = {{(EDGE_W-COORD_W){cur_r.left[COORD_W-1]}}, cur_r.left};
    c_top  = {{(EDGE_W-COORD_W){cur_r.top[COORD_W-1]}}, cur_r.top};
    lo_x   = (c_left > k_left) ? c_left : k_left;
    hi_x   = (cur_r.right < rd_r.right) ? cur_r.right : rd_r.right;
    lo_y   = (c_top > k_top) ? c_top : k_top;
    hi_y   = (cur_r.bottom < rd_r.bottom) ? cur_r.bottom : rd_r.bottom;
    iw     = '0;
    ih     = '0;
    if (hi_x > lo_x) begin
      iw = LEN_W'(hi_x - lo_x);
    end
    if (hi_y > lo_y) begin
      ih = LEN_W'(hi_y - lo_y);
    end
  end

  // Suppress when inter / union > threshold, tested as inter * 2^16 > thr * union.
  assign over = {1'b0, inter5_r, 16'b0} > prod5_r;

  always_ff @(posedge clk) begin
    iw2_r    <= iw;
    ih2_r    <= ih;
    karea2_r <= rd_r.area;
    inter3_r <= AREA_W'(iw2_r) * AREA_W'(ih2_r);
    karea3_r <= karea2_r;
    uni4_r   <= {1'b0, cur_r.area} + {1'b0, karea3_r} - {1'b0, inter3_r};
    inter4_r <= inter3_r;
    prod5_r  <= PROD_W'(threshold) * PROD_W'(uni4_r);
    nz5_r    <= uni4_r != '0;
    inter5_r <= inter4_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && pop_valid) begin
      cur_r <= pop_data;
    end
    if (finish) begin
      keep_r   <= keep;
      number_r <= cur_r.number;
      total_r  <= store ? TOTAL_W'(count_inc) : TOTAL_W'(count_r);
      full_r   <= keep && !room;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      j_r         <= '0;
      pv_r        <= '0;
      supp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r <= {pv_r[PIPE_LEN-2:0], issue};
      if (issue) begin
        j_r <= j_r + CNT_W'(1);
      end
      if (pv_r[PIPE_LEN-1] && nz5_r && over) begin
        supp_r <= 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            j_r    <= '0;
            supp_r <= 1'b0;
            // empty the store before this box is tested
            if (pop_data.frame_start) begin
              count_r <= '0;
            end
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (store) begin
              count_r <= count_inc;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.keep       = keep_r;
  assign out_ch.box_number = number_r;
  assign out_ch.kept_total = total_r;
  assign out_ch.store_full = full_r;

endmodule

// ===== rtl/sorted_box_nms.sv =====
// Top level of the sorted-box greedy non-maximum suppression block.
`timescale 1ns / 1ps

// Boxes enter on in_box, sorted by falling score, one valid/ready transfer
// each; frame_start marks the first box of a frame and empties the kept store.
// Each box yields exactly one result on out_box: keep, its number within the
// frame, the kept-store fill after the box, and store_full when a kept box
// found no room. cfg_wr writes the Q0.16 overlap threshold; write it only
// while no box is in flight.
// Each box is tested in turn against all boxes kept so far in its frame, at
// most KEEP_DEPTH of them, from the oldest kept entry on: the engine reads the
// kept store through one memory read port, one entry per cycle, into a
// five-stage compare pipeline. Boxes are processed one at a time;
// a two-entry queue lets the input side take boxes while the engine is busy.
// A finished result waits in the output register while out_box.ready is low;
// the engine stalls before issuing the next result, and in_box stalls once the
// queue is full.
// Reset empties the kept store, restarts box numbering and sets the threshold
// to 29491 (about 0.45). No clearing pass is needed.
module sorted_box_nms #(
  parameter int KEEP_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  snms_in_if.sink    in_box,
  snms_out_if.source out_box,
  snms_cfg_if.sink   cfg_wr
);
  import snms_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             q_push_valid;
  logic             q_push_ready;
  item_t            q_push_data;
  logic             q_pop_valid;
  logic             q_pop_ready;
  item_t            q_pop_data;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr.valid) begin
      thr_r <= cfg_wr.data;
    end
  end

  snms_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_box),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  snms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  snms_back #(
    .KEEP_DEPTH (KEEP_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_ch    (out_box)
  );

endmodule
